@@ rtl/dstk_pkg.sv @@
// Shared types and codes for the duplicate-rejecting stack.
`default_nettype none

package dstk_pkg;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_SHOW = 2'd2;

	localparam logic [2:0] ST_PUSHED    = 3'd0;
	localparam logic [2:0] ST_DUP       = 3'd1;
	localparam logic [2:0] ST_OVERFLOW  = 3'd2;
	localparam logic [2:0] ST_POPPED    = 3'd3;
	localparam logic [2:0] ST_UNDERFLOW = 3'd4;
	localparam logic [2:0] ST_ENTRY     = 3'd5;
	localparam logic [2:0] ST_EMPTY     = 3'd6;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] data;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic use_idx;
		logic emit_push;
		logic emit_pop;
		logic emit_show;
		logic show_adv;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic fill_zero;
		logic show_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/dstk_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dstk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/dstk_dp.sv @@
// Datapath: entry RAM, fill count, scan index, duplicate flag and result register.
`default_nettype none

module dstk_dp #(
	parameter int DEPTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dstk_pkg::cmd_t     cmd,
	output dstk_pkg::sts_t          sts,
	input  wire logic signed [31:0] value,
	input  wire logic               rsp_stall,
	output logic                    rsp_valid,
	output dstk_pkg::rsp_t          rsp
);

	import dstk_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]      fill_q;
	logic [CW-1:0]      idx_q;
	logic signed [31:0] value_q;
	logic               rdv_s1;
	logic               hit_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	rsp_t               rsp_d;

	logic [CW-1:0] fill_dec;
	logic [CW-1:0] fill_inc;
	logic [CW-1:0] idx_inc;
	logic [AW-1:0] raddr;
	logic [31:0]   rdata;
	logic          we;
	logic          more;
	logic          full;
	logic          fill_zero;
	logic          show_last;
	logic          out_free;
	logic          emit;

	assign fill_dec  = fill_q - CW'(1);
	assign fill_inc  = fill_q + CW'(1);
	assign idx_inc   = idx_q + CW'(1);
	assign more      = idx_q != fill_q;
	assign full      = fill_q == CW'(DEPTH);
	assign fill_zero = fill_q == '0;
	assign show_last = idx_inc == fill_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign raddr     = cmd.use_idx ? idx_q[AW-1:0] : fill_dec[AW-1:0];
	assign we        = cmd.emit_push && !hit_q && !full;
	assign emit      = cmd.emit_push || cmd.emit_pop || cmd.emit_show;

	assign sts.scan_done = !more && !rdv_s1;
	assign sts.fill_zero = fill_zero;
	assign sts.show_last = show_last;
	assign sts.out_free  = out_free;

	dstk_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(fill_q[AW-1:0]),
		.wdata(value_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		rsp_d.status = ST_PUSHED;
		rsp_d.data   = '0;
		rsp_d.last   = 1'b1;
		if (cmd.emit_push) begin
			if (hit_q) begin
				rsp_d.status = ST_DUP;
			end else if (full) begin
				rsp_d.status = ST_OVERFLOW;
			end else begin
				rsp_d.status = ST_PUSHED;
			end
		end else if (cmd.emit_pop) begin
			if (fill_zero) begin
				rsp_d.status = ST_UNDERFLOW;
			end else begin
				rsp_d.status = ST_POPPED;
				rsp_d.data   = $signed(rdata);
			end
		end else if (cmd.emit_show) begin
			if (fill_zero) begin
				rsp_d.status = ST_EMPTY;
			end else begin
				rsp_d.status = ST_ENTRY;
				rsp_d.data   = $signed(rdata);
				rsp_d.last   = show_last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			idx_q       <= '0;
			rdv_s1      <= 1'b0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				idx_q  <= '0;
				rdv_s1 <= 1'b0;
				hit_q  <= 1'b0;
			end else begin
				if (cmd.scan) begin
					// one read per cycle, compare in the cycle after the read
					if (more) begin
						idx_q <= idx_inc;
					end
					rdv_s1 <= more;
					if (rdv_s1 && (rdata == value_q)) begin
						hit_q <= 1'b1;
					end
				end
				if (cmd.show_adv) begin
					idx_q <= idx_inc;
				end
			end

			if (we) begin
				fill_q <= fill_inc;
			end else if (cmd.emit_pop && !fill_zero) begin
				fill_q <= fill_dec;
			end

			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			value_q <= value;
		end
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

@@ rtl/dstk_ctrl.sv @@
// Controller: sequences push scans, pops and display walks.
`default_nettype none

module dstk_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire logic [1:0]     req_op,
	output logic                req_stall,
	input  wire dstk_pkg::sts_t sts,
	output dstk_pkg::cmd_t      cmd
);

	import dstk_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_POP  = 3'd2;
	localparam logic [2:0] S_SRD  = 3'd3;
	localparam logic [2:0] S_SEM  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign req_stall = state_q != S_IDLE;
	assign accept    = req_valid && !req_stall;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.use_idx   = (state_q == S_SCAN) || (state_q == S_SRD) || (state_q == S_SEM);
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_op)
						OP_PUSH: begin
							cmd.start = 1'b1;
							state_d   = S_SCAN;
						end
						OP_POP: begin
							state_d = S_POP;
						end
						OP_SHOW: begin
							cmd.start = 1'b1;
							state_d   = S_SRD;
						end
						default: begin
							// unused op: drop the item
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done && sts.out_free) begin
					cmd.emit_push = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_POP: begin
				if (sts.out_free) begin
					cmd.emit_pop = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_SRD: begin
				if (sts.fill_zero) begin
					if (sts.out_free) begin
						cmd.emit_show = 1'b1;
						state_d       = S_IDLE;
					end
				end else begin
					state_d = S_SEM;
				end
			end
			S_SEM: begin
				if (sts.out_free) begin
					cmd.emit_show = 1'b1;
					cmd.show_adv  = 1'b1;
					state_d       = sts.show_last ? S_IDLE : S_SRD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/dedup_stack.sv @@
// Top level of the duplicate-rejecting stack.
//
// Requests enter on req (op, value) under req_valid/req_stall; results leave on
// rsp (status, data, last) under rsp_valid/rsp_stall. An item is taken at an edge
// where valid is high and stall is low. One request is worked at a time.
// Push: the entry RAM is scanned one read per cycle from the bottom entry up;
//   once the scan is done and the output register is free, the result is
//   registered; a duplicate, overflow or pushed status follows.
// Pop: the top entry is read at the accept edge, then registered as the result.
// Display: each stored entry is read in S_SRD and emitted in S_SEM, bottom to
//   top, last marked on the top entry; an empty stack gives one empty result.
// The next request is taken as soon as the controller is idle, even while the
// previous result still sits in the output register.
// A stalled receiver holds the output register; the controller waits for it
// before producing the next result.
// Reset empties the stack at once; RAM contents are left as they are and are
// only read below the fill count.
`default_nettype none

module dedup_stack #(
	parameter int DEPTH = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire dstk_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output dstk_pkg::rsp_t      rsp
);

	import dstk_pkg::*;

	cmd_t cmd;
	sts_t sts;

	dstk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_op   (req.op),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dstk_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.value    (req.value),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire
